@@ sv/rsi_pkg.sv @@
package rsi_pkg;

  // counter width of the tick and off-time counters
  localparam int unsigned CountWidth = 16;
  localparam int unsigned HoldWidth  = 16;
  localparam int unsigned CmpWidth   = (CountWidth > HoldWidth) ? CountWidth : HoldWidth;

  localparam logic [HoldWidth-1:0]  HoldReset = HoldWidth'(2000);
  localparam logic [CountWidth-1:0] CntMax    = {CountWidth{1'b1}};

  // selector codes
  localparam logic [1:0] SelNeutral = 2'd0;

  // item kinds
  localparam logic FuncTick = 1'b0;
  localparam logic FuncStop = 1'b1;

  typedef enum logic [1:0] {
    ViewOff     = 2'd0,
    ViewOn      = 2'd1,
    ViewLocked  = 2'd2,
    ViewStopped = 2'd3
  } view_e;

  typedef logic [CountWidth-1:0] cnt_t;
  typedef logic [HoldWidth-1:0]  hold_t;

  // guard state as seen after the current item
  typedef struct packed {
    logic locked;
    logic shown;
    logic stop;
  } guard_stat_t;

  typedef struct packed {
    logic  design_relay_on;
    logic  press_relay_on;
    view_e design_view;
    view_e press_view;
    logic  interlock_shown;
    logic  stop_latched_any;
    logic  stop_hit_running;
  } result_t;

  function automatic cnt_t sat_inc(cnt_t v);
    cnt_t r;
    r = (v == CntMax) ? CntMax : v + cnt_t'(1);
    return r;
  endfunction

  function automatic logic reaches_hold(cnt_t v, hold_t h);
    logic r;
    r = CmpWidth'(v) >= CmpWidth'(h);
    return r;
  endfunction

  function automatic view_e view_of(logic on, guard_stat_t g);
    view_e r;
    if (on) begin
      r = ViewOn;
    end else if (g.locked && g.shown) begin
      r = ViewLocked;
    end else if (g.stop) begin
      r = ViewStopped;
    end else begin
      r = ViewOff;
    end
    return r;
  endfunction

endpackage

@@ sv/rsi_guard.sv @@
module rsi_guard (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_i,
  input  logic                stop_set_i,
  input  logic                input_off_i,
  input  rsi_pkg::cnt_t       ticks_i,
  input  rsi_pkg::hold_t      hold_i,
  output rsi_pkg::guard_stat_t stat_o
);

  logic          locked_q, locked_d;
  logic          shown_q, shown_d;
  logic          timing_q, timing_d;
  logic          stop_q, stop_d;
  rsi_pkg::cnt_t count_q, count_d;
  rsi_pkg::cnt_t count_inc;

  assign count_inc = rsi_pkg::sat_inc(count_q);

  always_comb begin
    locked_d = locked_q;
    shown_d  = shown_q;
    timing_d = timing_q;
    count_d  = count_q;
    stop_d   = stop_q;
    if (tick_i) begin
      if (locked_q) begin
        if (!input_off_i) begin
          timing_d = 1'b0;
          count_d  = '0;
          if (rsi_pkg::reaches_hold(ticks_i, hold_i)) begin
            shown_d = 1'b1;
          end
        end else if (!timing_q) begin
          timing_d = 1'b1;
          count_d  = '0;
        end else begin
          count_d = count_inc;
          if (rsi_pkg::reaches_hold(count_inc, hold_i)) begin
            locked_d = 1'b0;
          end
        end
      end
      if (stop_q && input_off_i) begin
        stop_d = 1'b0;
      end
    end
    if (stop_set_i) begin
      stop_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q <= 1'b1;
      shown_q  <= 1'b0;
      timing_q <= 1'b0;
      count_q  <= '0;
      stop_q   <= 1'b0;
    end else begin
      locked_q <= locked_d;
      shown_q  <= shown_d;
      timing_q <= timing_d;
      count_q  <= count_d;
      stop_q   <= stop_d;
    end
  end

  assign stat_o = '{locked: locked_d, shown: shown_d, stop: stop_d};

endmodule

@@ sv/relay_safety_interlock_unit.sv @@
// result: registered in the output register, or in the skid entry on a stall
// throughput: one item per cycle; a two-entry output buffer keeps input ready
//   while one result waits, so in_ready_o only drops when both entries are full
// reset: asynchronous active low; both relays off, both outputs interlocked,
//   stop latches and counters cleared, hold register back to 2000
module relay_safety_interlock_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic       button_on_i,
  input  logic [1:0] selector_position_i,
  input  logic       selector_fault_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       design_relay_on_o,
  output logic       press_relay_on_o,
  output logic [1:0] design_view_o,
  output logic [1:0] press_view_o,
  output logic       interlock_shown_o,
  output logic       stop_latched_any_o,
  output logic       stop_hit_running_o
);

  // configuration register
  rsi_pkg::hold_t hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= rsi_pkg::HoldReset;
    end else if (cfg_we_i) begin
      hold_q <= cfg_wdata_i;
    end
  end

  // item decode
  logic in_xfer;
  logic is_tick;
  logic is_stop;
  logic sel_middle;
  logic press_asks;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_tick    = in_xfer && (func_i == rsi_pkg::FuncTick);
  assign is_stop    = in_xfer && (func_i == rsi_pkg::FuncStop);
  assign sel_middle = (selector_position_i == rsi_pkg::SelNeutral) && !selector_fault_i;
  // a stop latches the press side on any non-middle position, fault or not
  assign press_asks = selector_position_i != rsi_pkg::SelNeutral;

  // boot timer, advances before the guards look at it
  rsi_pkg::cnt_t ticks_q, ticks_d;

  assign ticks_d = is_tick ? rsi_pkg::sat_inc(ticks_q) : ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= '0;
    end else begin
      ticks_q <= ticks_d;
    end
  end

  // per-output interlock and stop latch
  rsi_pkg::guard_stat_t design_stat;
  rsi_pkg::guard_stat_t press_stat;

  rsi_guard u_design_guard (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (is_tick),
    .stop_set_i (is_stop && button_on_i),
    .input_off_i(!button_on_i),
    .ticks_i    (ticks_d),
    .hold_i     (hold_q),
    .stat_o     (design_stat)
  );

  rsi_guard u_press_guard (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (is_tick),
    .stop_set_i (is_stop && press_asks),
    .input_off_i(sel_middle),
    .ticks_i    (ticks_d),
    .hold_i     (hold_q),
    .stat_o     (press_stat)
  );

  // relay drive, recomputed on every tick and forced off by a stop
  logic design_relay_q, design_relay_d;
  logic press_relay_q, press_relay_d;

  always_comb begin
    design_relay_d = design_relay_q;
    press_relay_d  = press_relay_q;
    if (is_tick) begin
      design_relay_d = button_on_i && !design_stat.locked && !design_stat.stop;
      press_relay_d  = !sel_middle && !selector_fault_i && !press_stat.locked
                       && !press_stat.stop;
    end else if (is_stop) begin
      design_relay_d = 1'b0;
      press_relay_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      design_relay_q <= 1'b0;
      press_relay_q  <= 1'b0;
    end else begin
      design_relay_q <= design_relay_d;
      press_relay_q  <= press_relay_d;
    end
  end

  // result of the current item
  rsi_pkg::result_t res;

  always_comb begin
    res.design_relay_on  = design_relay_d;
    res.press_relay_on   = press_relay_d;
    res.design_view      = rsi_pkg::view_of(design_relay_d, design_stat);
    res.press_view       = rsi_pkg::view_of(press_relay_d, press_stat);
    res.interlock_shown  = (design_stat.locked && design_stat.shown)
                           || (press_stat.locked && press_stat.shown);
    res.stop_latched_any = design_stat.stop || press_stat.stop;
    res.stop_hit_running = is_stop && (design_relay_q || press_relay_q);
  end

  // output register plus skid entry
  logic              out_v_q;
  logic              skid_v_q;
  rsi_pkg::result_t  out_q;
  rsi_pkg::result_t  skid_q;
  logic              out_free;

  assign in_ready_o = !skid_v_q;
  assign out_free   = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (in_xfer) begin
        out_q <= res;
      end
    end else if (in_xfer) begin
      skid_q <= res;
    end
  end

  assign out_valid_o        = out_v_q;
  assign design_relay_on_o  = out_q.design_relay_on;
  assign press_relay_on_o   = out_q.press_relay_on;
  assign design_view_o      = 2'(out_q.design_view);
  assign press_view_o       = 2'(out_q.press_view);
  assign interlock_shown_o  = out_q.interlock_shown;
  assign stop_latched_any_o = out_q.stop_latched_any;
  assign stop_hit_running_o = out_q.stop_hit_running;

endmodule

@@ tb/relay_scoreboard_pkg.sv @@
package relay_scoreboard_pkg;

  import rsi_pkg::*;

  class relay_scoreboard;

    typedef struct {
      logic locked;
      logic shown;
      logic timing;
      cnt_t count;
      logic stop;
    } guard_state_t;

    hold_t        hold;
    cnt_t         uptime;
    guard_state_t guards[2];
    logic         design_on;
    logic         press_on;
    result_t      relay_states_q[$];
    int           errors;

    function new();
      hold      = HoldReset;
      uptime    = '0;
      design_on = 1'b0;
      press_on  = 1'b0;
      errors    = 0;
      foreach (guards[i]) begin
        guards[i].locked = 1'b1;
        guards[i].shown  = 1'b0;
        guards[i].timing = 1'b0;
        guards[i].count  = '0;
        guards[i].stop   = 1'b0;
      end
    endfunction

    function void write_hold(hold_t v);
      hold = v;
    endfunction

    function int pending();
      return relay_states_q.size();
    endfunction

    // saturating count
    function cnt_t bump(cnt_t v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void advance_guard(int idx, logic input_off);
      if (guards[idx].locked) begin
        if (!input_off) begin
          guards[idx].timing = 1'b0;
          guards[idx].count  = '0;
          if (uptime >= hold) guards[idx].shown = 1'b1;
        end else if (!guards[idx].timing) begin
          guards[idx].timing = 1'b1;
          guards[idx].count  = '0;
        end else begin
          guards[idx].count = bump(guards[idx].count);
          if (guards[idx].count >= hold) guards[idx].locked = 1'b0;
        end
      end
      if (guards[idx].stop && input_off) guards[idx].stop = 1'b0;
    endfunction

    function view_e view_for(int idx, logic on);
      if (on) return ViewOn;
      if (guards[idx].locked && guards[idx].shown) return ViewLocked;
      if (guards[idx].stop) return ViewStopped;
      return ViewOff;
    endfunction

    function void note_item(logic func, logic button, logic [1:0] pos, logic fault);
      result_t r;
      logic    sel_mid;
      logic    hit;
      hit = 1'b0;
      if (func == FuncTick) begin
        sel_mid = (pos == SelNeutral) && !fault;
        uptime  = bump(uptime);
        advance_guard(0, !button);
        advance_guard(1, sel_mid);
        design_on = button && !guards[0].locked && !guards[0].stop;
        press_on  = !sel_mid && !fault && !guards[1].locked && !guards[1].stop;
      end else begin
        hit = design_on || press_on;
        if (button) guards[0].stop = 1'b1;
        if (pos != SelNeutral) guards[1].stop = 1'b1;
        design_on = 1'b0;
        press_on  = 1'b0;
      end
      r.design_relay_on  = design_on;
      r.press_relay_on   = press_on;
      r.design_view      = view_for(0, design_on);
      r.press_view       = view_for(1, press_on);
      r.interlock_shown  = (guards[0].locked && guards[0].shown) ||
                           (guards[1].locked && guards[1].shown);
      r.stop_latched_any = guards[0].stop || guards[1].stop;
      r.stop_hit_running = hit;
      relay_states_q.push_back(r);
    endfunction

    function void field_check(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (relay_states_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = relay_states_q.pop_front();
      field_check("design_relay_on", want.design_relay_on, got.design_relay_on);
      field_check("press_relay_on", want.press_relay_on, got.press_relay_on);
      field_check("design_view", want.design_view, got.design_view);
      field_check("press_view", want.press_view, got.press_view);
      field_check("interlock_shown", want.interlock_shown, got.interlock_shown);
      field_check("stop_latched_any", want.stop_latched_any, got.stop_latched_any);
      field_check("stop_hit_running", want.stop_hit_running, got.stop_hit_running);
    endfunction

  endclass

endpackage

@@ tb/testbench.sv @@
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import rsi_pkg::*;
  import relay_scoreboard_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        func_i;
  logic        button_on_i;
  logic [1:0]  selector_position_i;
  logic        selector_fault_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        design_relay_on_o;
  logic        press_relay_on_o;
  logic [1:0]  design_view_o;
  logic [1:0]  press_view_o;
  logic        interlock_shown_o;
  logic        stop_latched_any_o;
  logic        stop_hit_running_o;

  relay_scoreboard sb;

  // idle-free stretches, one flag per side
  bit tx_calm;
  bit rx_calm;
  // long receiver hold-off, raised once by its own process
  bit rx_hold;
  int accepted;

  relay_safety_interlock_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .func_i              (func_i),
    .button_on_i         (button_on_i),
    .selector_position_i (selector_position_i),
    .selector_fault_i    (selector_fault_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .design_relay_on_o   (design_relay_on_o),
    .press_relay_on_o    (press_relay_on_o),
    .design_view_o       (design_view_o),
    .press_view_o        (press_view_o),
    .interlock_shown_o   (interlock_shown_o),
    .stop_latched_any_o  (stop_latched_any_o),
    .stop_hit_running_o  (stop_hit_running_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // one item: random gap first, then hold valid until the transfer
  task automatic send_item(logic f, logic b, logic [1:0] p, logic flt);
    int unsigned gap;
    gap = (tx_calm || rx_hold) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    func_i              <= f;
    button_on_i         <= b;
    selector_position_i <= p;
    selector_fault_i    <= flt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(f, b, p, flt);
    accepted++;
  endtask

  // register writes only once the block has drained
  task automatic write_hold(hold_t v);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // leave a little margin before the write
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_hold(v);
  endtask

  // segments with steady inputs so off runs get long enough to release
  task automatic run_random(int n);
    int         sent;
    int         seg_len;
    logic       seg_b;
    logic [1:0] seg_p;
    bit         b_steady;
    bit         p_steady;
    bit         fault_seg;
    logic       f;
    logic       b;
    logic [1:0] p;
    logic       flt;
    sent = 0;
    while (sent < n) begin
      seg_len   = $urandom_range(1, 40);
      seg_b     = logic'($urandom_range(0, 1));
      seg_p     = 2'($urandom_range(0, 3));
      b_steady  = ($urandom_range(0, 4) != 0);
      p_steady  = ($urandom_range(0, 4) != 0);
      fault_seg = ($urandom_range(0, 7) == 0);
      tx_calm   = ($urandom_range(0, 3) == 0);
      rx_calm   = ($urandom_range(0, 3) == 0);
      repeat (seg_len) begin
        f   = ($urandom_range(0, 9) == 0) ? FuncStop : FuncTick;
        b   = b_steady ? seg_b : logic'($urandom_range(0, 1));
        p   = p_steady ? seg_p : 2'($urandom_range(0, 3));
        flt = fault_seg ? logic'($urandom_range(0, 1)) : logic'($urandom_range(0, 31) == 0);
        send_item(f, b, p, flt);
        sent++;
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // result side: random stall, then wait for the transfer and check it
  initial begin
    int unsigned stall;
    result_t     got;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 8);
      if (stall != 0 || rx_hold) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (rx_hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.design_relay_on  = design_relay_on_o;
      got.press_relay_on   = press_relay_on_o;
      got.design_view      = view_e'(design_view_o);
      got.press_view       = view_e'(press_view_o);
      got.interlock_shown  = interlock_shown_o;
      got.stop_latched_any = stop_latched_any_o;
      got.stop_hit_running = stop_hit_running_o;
      sb.check_result(got);
    end
  end

  // back-pressure: hold the result side off long enough to fill the buffer
  initial begin
    rx_hold <= 1'b0;
    wait (accepted >= 700);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    sb = new();
    tx_calm  = 1'b0;
    rx_calm  = 1'b0;
    accepted = 0;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    in_valid_i          <= 1'b0;
    func_i              <= FuncTick;
    button_on_i         <= 1'b0;
    selector_position_i <= SelNeutral;
    selector_fault_i    <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset hold: boot time not yet passed, locks stay hidden
    send_item(FuncTick, 1'b0, 2'd0, 1'b0);
    send_item(FuncTick, 1'b1, 2'd0, 1'b0);
    send_item(FuncTick, 1'b0, 2'd1, 1'b0);
    send_item(FuncTick, 1'b0, 2'd2, 1'b0);
    // selector code three counts as heat
    send_item(FuncTick, 1'b0, 2'd3, 1'b0);
    // wiring fault in middle position never reads as off
    send_item(FuncTick, 1'b0, 2'd0, 1'b1);
    send_item(FuncTick, 1'b1, 2'd3, 1'b1);
    send_item(FuncStop, 1'b1, 2'd1, 1'b0);
    send_item(FuncTick, 1'b1, 2'd2, 1'b0);
    send_item(FuncTick, 1'b0, 2'd0, 1'b0);
    send_item(FuncStop, 1'b0, 2'd0, 1'b0);
    // stop during a fault still latches the press side
    send_item(FuncStop, 1'b1, 2'd3, 1'b1);
    send_item(FuncTick, 1'b0, 2'd0, 1'b0);

    // zero hold: lock shown at once, released on the second off tick
    write_hold(hold_t'(0));
    send_item(FuncTick, 1'b1, 2'd1, 1'b0);
    send_item(FuncTick, 1'b0, 2'd1, 1'b0);
    send_item(FuncTick, 1'b0, 2'd2, 1'b0);
    send_item(FuncTick, 1'b1, 2'd2, 1'b1);
    // stop while the design relay runs
    send_item(FuncStop, 1'b1, 2'd2, 1'b0);
    send_item(FuncTick, 1'b1, 2'd1, 1'b0);
    send_item(FuncTick, 1'b0, 2'd2, 1'b0);
    send_item(FuncTick, 1'b1, 2'd0, 1'b1);
    send_item(FuncStop, 1'b0, 2'd3, 1'b1);
    send_item(FuncTick, 1'b1, 2'd0, 1'b0);

    // random phases over several hold settings, extremes included
    write_hold(hold_t'(16'hFFFF));
    run_random(300);
    write_hold(hold_t'(12));
    run_random(500);
    write_hold(hold_t'(0));
    run_random(300);
    write_hold(hold_t'(1));
    run_random(300);
    write_hold(hold_t'($urandom_range(0, 40)));
    run_random(480);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS relay_safety_interlock_unit");
    end else begin
      $display("FAIL relay_safety_interlock_unit");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("FAIL relay_safety_interlock_unit");
    $finish;
  end

endmodule
